FILE: rtl/core/physical_frame_bitmap_allocator_top_defines.svh
// Assertion macros shared by the frame allocator RTL.
`ifndef PHYSICAL_FRAME_BITMAP_ALLOCATOR_TOP_DEFINES_SVH
`define PHYSICAL_FRAME_BITMAP_ALLOCATOR_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define PFBA_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("frame allocator assertion failed");
`define PFBA_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  `PFBA_ASSERT(lbl, clk, rst, (ante) |-> (cons))
`else
`define PFBA_ASSERT(lbl, clk, rst, prop)
`define PFBA_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/core/pfba_pkg.sv
// Types and constants of the physical frame bitmap allocator.
`default_nettype none
package pfba_pkg;

  localparam int WORD_W    = 32;
  localparam int OFS_W     = 5;
  localparam int COUNT_W   = 11;
  localparam int IDX_W     = 10;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int REQ_W     = 2;
  localparam int STATUS_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESERVED_BELOW = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STACK_FIRST    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STACK_LIMIT    = 2'd3;

  typedef enum logic [REQ_W-1:0] {
    REQ_INIT  = 2'd0,
    REQ_ALLOC = 2'd1,
    REQ_FREE  = 2'd2,
    REQ_MARK  = 2'd3
  } pfba_req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NONE_FREE = 2'd1,
    ST_RANGE     = 2'd2
  } pfba_status_t;

  typedef struct packed {
    logic              found;
    logic [OFS_W-1:0]  pos;
    logic [WORD_W-1:0] set_word;
    logic [WORD_W-1:0] init_word;
  } pfba_word_t;

endpackage
`default_nettype wire

FILE: rtl/core/pfba_req_if.sv
// Request channel of the frame allocator.
`default_nettype none
interface pfba_req_if import pfba_pkg::*;;
  logic             valid;
  logic             ready;
  logic [REQ_W-1:0] req_type;
  logic [IDX_W-1:0] frame_index;

  modport source (output valid, output req_type, output frame_index, input ready);
  modport sink (input valid, input req_type, input frame_index, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/pfba_res_if.sv
// Result channel of the frame allocator.
`default_nettype none
interface pfba_res_if import pfba_pkg::*;;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [IDX_W-1:0]    granted_frame;

  modport source (output valid, output status, output granted_frame, input ready);
  modport sink (input valid, input status, input granted_frame, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/pfba_map_ram.sv
// Word-wide used-bit memory with one write port and a registered read port.
`default_nettype none
module pfba_map_ram import pfba_pkg::*; #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [WORD_W-1:0] wdata,
  input  logic [AW-1:0]     raddr,
  output logic [WORD_W-1:0] rdata
);

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/core/pfba_word_unit.sv
// Shared word unit: range masks for init and first-free search for allocate.
`default_nettype none
module pfba_word_unit import pfba_pkg::*; #(
  parameter int FW = 11
) (
  input  logic [FW-1:0]     base,
  input  logic [WORD_W-1:0] data,
  input  logic [FW-1:0]     count,
  input  logic [FW-1:0]     res_lim,
  input  logic [FW-1:0]     stk_lo,
  input  logic [FW-1:0]     stk_hi,
  output pfba_word_t        word_o
);

  // Bits of the word at base whose frame lies below lim.
  function automatic logic [WORD_W-1:0] below(input logic [FW-1:0] lim,
                                                input logic [FW-1:0] b);
    logic [FW-1:0]     d;
    logic [WORD_W-1:0] r;
    d = lim - b;
    if (lim <= b) begin
      r = '0;
    end else if (d >= FW'(WORD_W)) begin
      r = '1;
    end else begin
      r = (WORD_W'(1) << d[OFS_W-1:0]) - WORD_W'(1);
    end
    return r;
  endfunction

  logic [WORD_W-1:0] free_bits;
  logic [OFS_W-1:0]  pos;

  assign free_bits = ~data & below(count, base);

  always_comb begin
    pos = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        pos = OFS_W'(i);
      end
    end
  end

  assign word_o.found     = |free_bits;
  assign word_o.pos       = pos;
  assign word_o.set_word  = data | (WORD_W'(1) << pos);
  assign word_o.init_word = below(res_lim, base) |
                            (below(stk_hi, base) & ~below(stk_lo, base));

endmodule
`default_nettype wire

FILE: rtl/core/physical_frame_bitmap_allocator_top.sv
// Top level of the first-fit physical frame bitmap allocator.
// Reset starts a clearing pass that writes every map word to zero; no request is taken meanwhile.
// Init: one map word written per cycle, over every word of the map.
// Allocate: one map word read and searched per cycle, up to the last word that holds a frame below count.
// Free and mark-used: read, modify-write, result; one request is in work at a time.
`default_nettype none
`include "physical_frame_bitmap_allocator_top_defines.svh"
module physical_frame_bitmap_allocator_top import pfba_pkg::*; #(
  parameter int MAX_FRAMES = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  pfba_req_if.sink             req,
  pfba_res_if.source           res,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int WORDS = (MAX_FRAMES + WORD_W - 1) / WORD_W;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int CNT_W = $clog2(WORDS + 1);
  localparam int FW    = (CNT_W + OFS_W > COUNT_W) ? CNT_W + OFS_W : COUNT_W;
  localparam logic [CNT_W-1:0] LAST_WORD = CNT_W'(WORDS - 1);
  localparam logic [FW-1:0]    CAP       = FW'(MAX_FRAMES);

  typedef enum logic [2:0] {CLR, IDLE, INIT, SCAN, RMW, PUSH} state_t;

  state_t             state;
  logic [CNT_W-1:0]   wcnt;
  logic [CNT_W-1:0]   rd_word;
  logic               chk;
  pfba_req_t          kind_r;
  logic [IDX_W-1:0]   idx_r;
  pfba_status_t       status_r;
  logic [IDX_W-1:0]   granted_r;

  logic [COUNT_W-1:0] frame_count;
  logic [COUNT_W-1:0] reserved_below;
  logic [IDX_W-1:0]   stack_first_frame;
  logic [COUNT_W-1:0] stack_limit_frame;

  logic [FW-1:0]      count_ext;
  logic [FW-1:0]      n;
  logic [FW-1:0]      nw;
  logic [FW-1:0]      res_lim;
  logic [FW-1:0]      stk_hi;
  logic [FW-1:0]      stk_lo;
  logic [FW-1:0]      base;
  logic [FW-1:0]      rd_next;
  logic [FW-1:0]      gsum;
  logic [CNT_W-1:0]   unit_word;
  pfba_word_t         word;

  logic               map_we;
  logic [AW-1:0]      map_waddr;
  logic [WORD_W-1:0]  map_wdata;
  logic [AW-1:0]      map_raddr;
  logic [WORD_W-1:0]  map_rdata;

  assign count_ext = FW'(frame_count);
  assign n         = (count_ext > CAP) ? CAP : count_ext;
  assign nw        = (n >> OFS_W) + FW'(|n[OFS_W-1:0]);
  assign res_lim   = (FW'(reserved_below) < n) ? FW'(reserved_below) : n;
  assign stk_hi    = (FW'(stack_limit_frame) < n) ? FW'(stack_limit_frame) : n;
  assign stk_lo    = FW'(stack_first_frame);
  assign unit_word = (state == SCAN) ? rd_word : wcnt;
  assign base      = FW'(unit_word) << OFS_W;
  assign rd_next   = FW'(rd_word) + FW'(1);
  assign gsum      = base + FW'(word.pos);

  assign req.ready = (state == IDLE);

  pfba_word_unit #(.FW(FW)) u_word (
    .base    (base),
    .data    (map_rdata),
    .count   (n),
    .res_lim (res_lim),
    .stk_lo  (stk_lo),
    .stk_hi  (stk_hi),
    .word_o  (word)
  );

  pfba_map_ram #(.DEPTH(WORDS), .AW(AW)) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  always_comb begin
    map_raddr = (state == IDLE) ? AW'(req.frame_index >> OFS_W) : wcnt[AW-1:0];
    map_we    = 1'b0;
    map_waddr = wcnt[AW-1:0];
    map_wdata = '0;
    case (state)
      CLR: begin
        map_we = 1'b1;
      end
      INIT: begin
        map_we    = 1'b1;
        map_wdata = word.init_word;
      end
      SCAN: begin
        map_we    = chk && word.found;
        map_waddr = rd_word[AW-1:0];
        map_wdata = word.set_word;
      end
      RMW: begin
        map_we    = 1'b1;
        map_waddr = AW'(idx_r >> OFS_W);
        map_wdata = map_rdata;
        map_wdata[idx_r[OFS_W-1:0]] = (kind_r == REQ_MARK);
      end
      default: begin
        map_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= CLR;
      wcnt              <= '0;
      chk               <= 1'b0;
      res.valid         <= 1'b0;
      frame_count       <= COUNT_W'(1024);
      reserved_below    <= '0;
      stack_first_frame <= '0;
      stack_limit_frame <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_FRAME_COUNT:    frame_count       <= cfg_data;
          CFG_RESERVED_BELOW: reserved_below    <= cfg_data;
          CFG_STACK_FIRST:    stack_first_frame <= cfg_data[IDX_W-1:0];
          CFG_STACK_LIMIT:    stack_limit_frame <= cfg_data;
          default: ;
        endcase
      end
      if (res.valid && res.ready && state != PUSH) begin
        res.valid <= 1'b0;
      end
      case (state)
        CLR: begin
          if (wcnt == LAST_WORD) begin
            wcnt  <= '0;
            state <= IDLE;
          end else begin
            wcnt <= wcnt + CNT_W'(1);
          end
        end
        IDLE: begin
          if (req.valid) begin
            kind_r    <= pfba_req_t'(req.req_type);
            idx_r     <= req.frame_index;
            wcnt      <= '0;
            chk       <= 1'b0;
            status_r  <= ST_OK;
            granted_r <= '0;
            case (pfba_req_t'(req.req_type))
              REQ_INIT: state <= INIT;
              REQ_ALLOC: begin
                if (n == '0) begin
                  status_r <= ST_NONE_FREE;
                  state    <= PUSH;
                end else begin
                  state <= SCAN;
                end
              end
              default: begin
                if (FW'(req.frame_index) >= n) begin
                  status_r <= ST_RANGE;
                  state    <= PUSH;
                end else begin
                  state <= RMW;
                end
              end
            endcase
          end
        end
        INIT: begin
          if (wcnt == LAST_WORD) begin
            state <= PUSH;
          end else begin
            wcnt <= wcnt + CNT_W'(1);
          end
        end
        SCAN: begin
          if (!chk) begin
            chk     <= 1'b1;
            rd_word <= wcnt;
            wcnt    <= wcnt + CNT_W'(1);
          end else if (word.found) begin
            granted_r <= gsum[IDX_W-1:0];
            state     <= PUSH;
          end else if (rd_next >= nw) begin
            status_r <= ST_NONE_FREE;
            state    <= PUSH;
          end else begin
            rd_word <= wcnt;
            wcnt    <= wcnt + CNT_W'(1);
          end
        end
        RMW: begin
          state <= PUSH;
        end
        PUSH: begin
          if (!res.valid || res.ready) begin
            res.valid         <= 1'b1;
            res.status        <= status_r;
            res.granted_frame <= granted_r;
            state             <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  `PFBA_ASSERT_IMPL(a_status_code, clk, rst, res.valid,
    res.status == ST_OK || res.status == ST_NONE_FREE || res.status == ST_RANGE)
  `PFBA_ASSERT_IMPL(a_grant_only_on_success, clk, rst, res.valid && res.status != ST_OK,
    res.granted_frame == '0)
  `PFBA_ASSERT_IMPL(a_no_write_on_accept, clk, rst, map_we, !(req.valid && req.ready))
  `PFBA_ASSERT(a_result_from_push, clk, rst, $rose(res.valid) |-> $past(state == PUSH))

endmodule
`default_nettype wire
